// ===== rtl/core/trpc_pkg.sv =====
// Shared types and constants of the timer rate plan calculator.
// Used by the top level calculator and its test bench.
`default_nettype none

package trpc_pkg;

	typedef enum logic [1:0] {
		REG_TIMER_CLOCK_HZ      = 2'd0,
		REG_MAX_RATE_HZ         = 2'd1,
		REG_MAX_RELOAD          = 2'd2,
		REG_MAX_PRESCALE_FACTOR = 2'd3
	} cfg_reg_t;

	localparam logic [31:0] TIMER_CLOCK_RESET = 32'd72000000;
	localparam logic [31:0] MAX_RATE_RESET    = 32'd1000000;
	localparam logic [15:0] MAX_RELOAD_RESET  = 16'hFFFF;
	localparam logic [16:0] MAX_PRESCALE_RESET = 17'd65536;
	localparam logic [19:0] PPM_SCALE         = 20'd1000000;

	// Context carried beside the tick count division.
	typedef struct packed {
		logic [31:0] req;
		logic        rej;
	} t1_ctx_t;

	// Context carried beside the prescale factor division.
	typedef struct packed {
		logic [31:0] req;
		logic        rej;
		logic [32:0] ticks;
	} t2_ctx_t;

	// Context carried beside the reload division.
	typedef struct packed {
		logic [31:0] req;
		logic        rej;
		logic [16:0] factor;
	} t3_ctx_t;

	// Context carried beside the actual rate division.
	typedef struct packed {
		logic [31:0] req;
		logic        rej;
		logic [16:0] factor;
		logic [16:0] reload;
	} t5_ctx_t;

	// Context carried beside the ppm division.
	typedef struct packed {
		logic [31:0] req;
		logic        rej;
		logic        neg;
		logic        sat;
		logic [31:0] actual;
		logic [16:0] factor;
		logic [16:0] reload;
	} t6_ctx_t;

endpackage

`default_nettype wire

// ===== rtl/core/trpc_req_if.sv =====
// Request channel: one requested sample rate per item.
// Depends on nothing else.
`default_nettype none

interface trpc_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] requested_hz;

	modport source(output valid, output requested_hz, input ready);
	modport sink(input valid, input requested_hz, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/trpc_plan_if.sv =====
// Plan channel: one computed timer plan per item.
// Depends on nothing else.
`default_nettype none

interface trpc_plan_if;
	logic               valid;
	logic               ready;
	logic               plan_ok;
	logic [31:0]        echo_requested_hz;
	logic [31:0]        actual_rate_hz;
	logic [15:0]        prescaler_value;
	logic [15:0]        reload_value;
	logic signed [20:0] deviation_ppm;

	modport source(output valid, output plan_ok, output echo_requested_hz,
		output actual_rate_hz, output prescaler_value, output reload_value,
		output deviation_ppm, input ready);
	modport sink(input valid, input plan_ok, input echo_requested_hz,
		input actual_rate_hz, input prescaler_value, input reload_value,
		input deviation_ppm, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/trpc_div_cell.sv =====
// One restoring division step with its pipeline register.
// Stands alone; chained by trpc_div_pipe.
`default_nettype none

module trpc_div_cell #(
	parameter int W = 32,
	parameter int D = 32,
	parameter int P = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire logic [W-1:0] in_dq,
	input  wire logic [D-1:0] in_rem,
	input  wire logic [D-1:0] in_divisor,
	input  wire logic [P-1:0] in_payload,
	output logic              out_valid,
	output logic [W-1:0]      out_dq,
	output logic [D-1:0]      out_rem,
	output logic [D-1:0]      out_divisor,
	output logic [P-1:0]      out_payload
);

	logic [D:0]   trial;
	logic         take;
	logic [D:0]   diff;
	logic         valid_s1;
	logic [W-1:0] dq_s1;
	logic [D-1:0] rem_s1;
	logic [D-1:0] div_s1;
	logic [P-1:0] pay_s1;

	// dq holds the dividend bits still to bring down at the top and the
	// quotient bits found so far at the bottom.
	always_comb begin
		trial = {in_rem, in_dq[W-1]};
		take  = trial >= {1'b0, in_divisor};
		diff  = trial - {1'b0, in_divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s1  <= {in_dq[W-2:0], take};
			rem_s1 <= take ? diff[D-1:0] : trial[D-1:0];
			div_s1 <= in_divisor;
			pay_s1 <= in_payload;
		end
	end

	assign out_valid   = valid_s1;
	assign out_dq      = dq_s1;
	assign out_rem     = rem_s1;
	assign out_divisor = div_s1;
	assign out_payload = pay_s1;

endmodule

`default_nettype wire

// ===== rtl/core/trpc_div_pipe.sv =====
// Pipelined divider: a row of trpc_div_cell, one quotient bit per cell.
// The starting remainder must be below the divisor for a valid quotient.
`default_nettype none

module trpc_div_pipe #(
	parameter int W = 32,
	parameter int D = 32,
	parameter int P = 1
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire logic [W-1:0] in_dividend,
	input  wire logic [D-1:0] in_rem,
	input  wire logic [D-1:0] in_divisor,
	input  wire logic [P-1:0] in_payload,
	output logic              out_valid,
	output logic [W-1:0]      out_quot,
	output logic [P-1:0]      out_payload
);

	logic         v   [0:W];
	logic [W-1:0] dq  [0:W];
	logic [D-1:0] rem [0:W];
	logic [D-1:0] dvs [0:W];
	logic [P-1:0] pay [0:W];

	assign v[0]   = in_valid;
	assign dq[0]  = in_dividend;
	assign rem[0] = in_rem;
	assign dvs[0] = in_divisor;
	assign pay[0] = in_payload;

	for (genvar i = 0; i < W; i++) begin : g_cell
		trpc_div_cell #(.W(W), .D(D), .P(P)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.in_valid    (v[i]),
			.in_dq       (dq[i]),
			.in_rem      (rem[i]),
			.in_divisor  (dvs[i]),
			.in_payload  (pay[i]),
			.out_valid   (v[i+1]),
			.out_dq      (dq[i+1]),
			.out_rem     (rem[i+1]),
			.out_divisor (dvs[i+1]),
			.out_payload (pay[i+1])
		);
	end

	assign out_valid   = v[W];
	assign out_quot    = dq[W];
	assign out_payload = pay[W];

endmodule

`default_nettype wire

// ===== rtl/core/timer_rate_plan_calculator.sv =====
// Timer rate plan calculator. Each request item gives one plan item, and a new
// request is taken every cycle while the plan channel takes results. The pipe
// is built from five chains of one-bit restoring divider cells (tick count
// 33, prescale factor 34, reload 33, actual rate 32 and ppm error 20 cells)
// plus four context stages and the output register. The whole pipe stalls
// only while a finished plan waits in the output register. Configuration is
// written through cfg_we, cfg_index and cfg_data and must only change while
// no request is in flight.
// Depends on trpc_pkg, trpc_req_if, trpc_plan_if and trpc_div_pipe.
`default_nettype none

module timer_rate_plan_calculator #(
	parameter int PRESCALER_WIDTH = 16,
	parameter int RELOAD_WIDTH    = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	trpc_req_if.sink         req,
	trpc_plan_if.source      plan
);

	localparam logic [15:0] PRE_MASK = (PRESCALER_WIDTH >= 16) ? 16'hFFFF :
		16'((32'd1 << PRESCALER_WIDTH) - 32'd1);
	localparam logic [15:0] REL_MASK = (RELOAD_WIDTH >= 16) ? 16'hFFFF :
		16'((32'd1 << RELOAD_WIDTH) - 32'd1);

	logic [31:0] timer_clock_q;
	logic [31:0] max_rate_q;
	logic [15:0] max_reload_q;
	logic [16:0] max_pf_q;
	logic [16:0] span;
	logic        en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_clock_q <= trpc_pkg::TIMER_CLOCK_RESET;
			max_rate_q    <= trpc_pkg::MAX_RATE_RESET;
			max_reload_q  <= trpc_pkg::MAX_RELOAD_RESET;
			max_pf_q      <= trpc_pkg::MAX_PRESCALE_RESET;
		end else if (cfg_we) begin
			case (trpc_pkg::cfg_reg_t'(cfg_index))
				trpc_pkg::REG_TIMER_CLOCK_HZ:      timer_clock_q <= cfg_data;
				trpc_pkg::REG_MAX_RATE_HZ:         max_rate_q    <= cfg_data;
				trpc_pkg::REG_MAX_RELOAD:          max_reload_q  <= cfg_data[15:0];
				trpc_pkg::REG_MAX_PRESCALE_FACTOR: max_pf_q      <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign span = {1'b0, max_reload_q} + 17'd1;

	logic out_valid_q;
	assign en        = !out_valid_q || plan.ready;
	assign req.ready = en;

	// Tick count: (clock + req / 2) / req.
	trpc_pkg::t1_ctx_t c1_in, c1_out;
	logic [32:0] d1_dividend, q1;
	logic        v1;

	assign d1_dividend = {1'b0, timer_clock_q} + {2'b0, req.requested_hz[31:1]};
	assign c1_in.req = req.requested_hz;
	assign c1_in.rej = (req.requested_hz == 32'd0) || (req.requested_hz > max_rate_q);

	trpc_div_pipe #(.W(33), .D(32), .P($bits(trpc_pkg::t1_ctx_t))) u_div_ticks (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_valid (req.valid), .in_dividend (d1_dividend), .in_rem ('0),
		.in_divisor (req.requested_hz), .in_payload (c1_in),
		.out_valid (v1), .out_quot (q1), .out_payload (c1_out)
	);

	// Prescale factor: ceiling of ticks over span.
	trpc_pkg::t2_ctx_t c2_in, c2_out;
	logic [33:0] d2_dividend, q2;
	logic        v2;

	assign d2_dividend = {1'b0, q1} + {18'b0, max_reload_q};
	assign c2_in.req   = c1_out.req;
	assign c2_in.rej   = c1_out.rej || (q1 == 33'd0);
	assign c2_in.ticks = q1;

	trpc_div_pipe #(.W(34), .D(17), .P($bits(trpc_pkg::t2_ctx_t))) u_div_factor (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_valid (v1), .in_dividend (d2_dividend), .in_rem ('0),
		.in_divisor (span), .in_payload (c2_in),
		.out_valid (v2), .out_quot (q2), .out_payload (c2_out)
	);

	logic [33:0] fac2;
	logic        valid_s2;
	trpc_pkg::t3_ctx_t c3_s2;
	logic [32:0] ticks_s2;

	assign fac2 = (q2 == 34'd0) ? 34'd1 : q2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c3_s2.req    <= c2_out.req;
			c3_s2.rej    <= c2_out.rej || (fac2 > {17'b0, max_pf_q});
			c3_s2.factor <= fac2[16:0];
			ticks_s2     <= c2_out.ticks;
		end
	end

	// Reload ticks: ticks / factor.
	trpc_pkg::t3_ctx_t c3_out;
	logic [32:0] q3;
	logic        v3;

	trpc_div_pipe #(.W(33), .D(17), .P($bits(trpc_pkg::t3_ctx_t))) u_div_reload (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_valid (valid_s2), .in_dividend (ticks_s2), .in_rem ('0),
		.in_divisor (c3_s2.factor), .in_payload (c3_s2),
		.out_valid (v3), .out_quot (q3), .out_payload (c3_out)
	);

	logic [16:0] rl3;
	logic        valid_s3;
	logic [33:0] prod_s3;
	trpc_pkg::t5_ctx_t c5_s3;

	always_comb begin
		if (q3 == 33'd0) begin
			rl3 = 17'd1;
		end else if (q3 > {16'b0, span}) begin
			rl3 = span;
		end else begin
			rl3 = q3[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3      <= c3_out.factor * rl3;
			c5_s3.req    <= c3_out.req;
			c5_s3.rej    <= c3_out.rej;
			c5_s3.factor <= c3_out.factor;
			c5_s3.reload <= rl3;
		end
	end

	// Actual rate: clock / (factor * reload).
	trpc_pkg::t5_ctx_t c5_out;
	logic [31:0] q5;
	logic        v5;

	trpc_div_pipe #(.W(32), .D(33), .P($bits(trpc_pkg::t5_ctx_t))) u_div_actual (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_valid (valid_s3), .in_dividend (timer_clock_q), .in_rem ('0),
		.in_divisor (prod_s3[32:0]), .in_payload (c5_s3),
		.out_valid (v5), .out_quot (q5), .out_payload (c5_out)
	);

	// The error magnitude saturates whenever it exceeds the request itself,
	// which leaves a quotient of at most 20 bits to compute.
	logic        neg4;
	logic [31:0] mag4;
	logic        valid_s4;
	logic [31:0] mag_s4;
	trpc_pkg::t6_ctx_t c6_s4;

	assign neg4 = q5 < c5_out.req;
	assign mag4 = neg4 ? (c5_out.req - q5) : (q5 - c5_out.req);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= v5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4        <= mag4;
			c6_s4.req     <= c5_out.req;
			c6_s4.rej     <= c5_out.rej;
			c6_s4.neg     <= neg4;
			c6_s4.sat     <= mag4 > c5_out.req;
			c6_s4.actual  <= q5;
			c6_s4.factor  <= c5_out.factor;
			c6_s4.reload  <= c5_out.reload;
		end
	end

	logic        valid_s5;
	logic [51:0] prod_s5;
	trpc_pkg::t6_ctx_t c6_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= mag_s4 * trpc_pkg::PPM_SCALE;
			c6_s5   <= c6_s4;
		end
	end

	// Error in ppm: the upper product bits form the starting remainder.
	trpc_pkg::t6_ctx_t c6_out;
	logic [19:0] q6;
	logic        v6;

	trpc_div_pipe #(.W(20), .D(32), .P($bits(trpc_pkg::t6_ctx_t))) u_div_ppm (
		.clk (clk), .arst_n (arst_n), .en (en),
		.in_valid (valid_s5), .in_dividend (prod_s5[19:0]), .in_rem (prod_s5[51:20]),
		.in_divisor (c6_s5.req), .in_payload (c6_s5),
		.out_valid (v6), .out_quot (q6), .out_payload (c6_out)
	);

	logic [20:0] ppm_mag;
	logic [20:0] ppm_val;
	logic [15:0] pre_val;
	logic [15:0] rel_val;
	logic [16:0] fac_m1;
	logic [16:0] rel_m1;

	always_comb begin
		ppm_mag = c6_out.sat ? {1'b0, trpc_pkg::PPM_SCALE} : {1'b0, q6};
		ppm_val = c6_out.neg ? (21'd0 - ppm_mag) : ppm_mag;
		fac_m1  = c6_out.factor - 17'd1;
		rel_m1  = c6_out.reload - 17'd1;
		pre_val = fac_m1[15:0] & PRE_MASK;
		rel_val = rel_m1[15:0] & REL_MASK;
	end

	logic               plan_ok_q;
	logic [31:0]        echo_q;
	logic [31:0]        actual_q;
	logic [15:0]        pre_q;
	logic [15:0]        rel_q;
	logic signed [20:0] ppm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (c6_out.rej) begin
				plan_ok_q <= 1'b0;
				echo_q    <= '0;
				actual_q  <= '0;
				pre_q     <= '0;
				rel_q     <= '0;
				ppm_q     <= '0;
			end else begin
				plan_ok_q <= c6_out.actual != 32'd0;
				echo_q    <= c6_out.req;
				actual_q  <= c6_out.actual;
				pre_q     <= pre_val;
				rel_q     <= rel_val;
				ppm_q     <= $signed(ppm_val);
			end
		end
	end

	assign plan.valid             = out_valid_q;
	assign plan.plan_ok           = plan_ok_q;
	assign plan.echo_requested_hz = echo_q;
	assign plan.actual_rate_hz    = actual_q;
	assign plan.prescaler_value   = pre_q;
	assign plan.reload_value      = rel_q;
	assign plan.deviation_ppm     = ppm_q;

`ifndef SYNTHESIS
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid && plan.plan_ok |-> plan.actual_rate_hz != 32'd0)
		else $error("plan marked ok with a zero actual rate");

	a_ppm_range: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid |-> (plan.deviation_ppm <= 21'sd1000000 &&
		plan.deviation_ppm >= -21'sd1000000))
		else $error("ppm error outside saturation bounds");

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!plan.valid || plan.ready))
		else $error("request ready does not follow the output register");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		plan.valid && plan.echo_requested_hz == 32'd0 |->
		!plan.plan_ok && plan.actual_rate_hz == 32'd0 && plan.deviation_ppm == 21'sd0)
		else $error("rejected plan carries nonzero fields");
`endif

endmodule

`default_nettype wire

// ===== test/timer_rate_plan_calculator_test.sv =====
// Self-checking bench for the timer rate plan calculator: random and directed rate
// requests with random handshake gaps, checked against a behavioral plan model.
// Depends on trpc_pkg, trpc_req_if, trpc_plan_if and the calculator RTL.
`timescale 1ns / 1ps

module timer_rate_plan_calculator_test;

	typedef struct packed {
		logic        plan_ok;
		logic [31:0] echo_requested_hz;
		logic [31:0] actual_rate_hz;
		logic [15:0] prescaler_value;
		logic [15:0] reload_value;
		logic [20:0] deviation_ppm;
	} plan_t;

	localparam int LATENCY = 160;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	trpc_req_if req ();
	trpc_plan_if plan ();

	timer_rate_plan_calculator i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .plan(plan.source)
	);

	always #5 clk = ~clk;

	// Model copy of the configuration registers.
	logic [31:0] timer_clock;
	logic [31:0] max_rate;
	logic [15:0] max_reload;
	logic [16:0] max_factor;

	// Zero rate, above maximum, extremes, prescale factor step from one to two.
	logic [31:0] directed_rates [0:10] = '{32'd0, 32'd1, 32'd2, 32'd1000000,
		32'd1000001, 32'hFFFF_FFFF, 32'd1099, 32'd1098, 32'd48000, 32'd7, 32'd999999};

	logic [31:0] pending_rates[$];
	plan_t expected_plans[$];
	int errors = 0;
	int plans_seen = 0;
	int ok_plans = 0;
	int cycles = 0;
	int hold_plan = 0;
	bit sender_paused = 1'b0;

	function automatic plan_t compute_plan(logic [31:0] rate);
		plan_t p;
		logic [63:0] ticks, span, factor, reload, actual;
		longint diff, ppm;
		p = '0;
		if (rate == 0 || rate > max_rate)
			return p;
		ticks = (64'(timer_clock) + 64'(rate) / 2) / 64'(rate);
		if (ticks == 0)
			return p;
		span = 64'(max_reload) + 1;
		factor = (ticks + 64'(max_reload)) / span;
		if (factor == 0)
			factor = 1;
		if (factor > 64'(max_factor))
			return p;
		reload = ticks / factor;
		if (reload == 0)
			reload = 1;
		if (reload > span)
			reload = span;
		actual = (64'(timer_clock) / (factor * reload)) & 64'hFFFF_FFFF;
		diff = longint'(actual) - longint'(rate);
		ppm = (diff * 1000000) / longint'(rate);
		if (ppm > 1000000)
			ppm = 1000000;
		if (ppm < -1000000)
			ppm = -1000000;
		p.plan_ok = (actual != 0);
		p.echo_requested_hz = rate;
		p.actual_rate_hz = actual[31:0];
		p.prescaler_value = 16'(factor - 1);
		p.reload_value = 16'(reload - 1);
		p.deviation_ppm = 21'(ppm);
		return p;
	endfunction

	task automatic write_reg(trpc_pkg::cfg_reg_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			trpc_pkg::REG_TIMER_CLOCK_HZ: timer_clock = value;
			trpc_pkg::REG_MAX_RATE_HZ: max_rate = value;
			trpc_pkg::REG_MAX_RELOAD: max_reload = value[15:0];
			trpc_pkg::REG_MAX_PRESCALE_FACTOR: max_factor = value[16:0];
			default: ;
		endcase
	endtask

	// Sampled at the falling edge so that the driver's updates have settled.
	task automatic wait_results();
		@(negedge clk);
		while (expected_plans.size() != 0 || req.valid)
			@(negedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_rates.size() != 0)
			@(negedge clk);
		wait_results();
	endtask

	// Mostly rates near the accepted range, plus full-width noise.
	function automatic logic [31:0] random_rate();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 20);
			2: return max_rate + $urandom_range(0, 3);
			default: return (max_rate == 0) ? 32'd1 : $urandom_range(1, max_rate);
		endcase
	endfunction

	// Driver: offers queued rates after a random gap per item; a gap of zero
	// keeps valid high and sends the next item back to back.
	int send_gap = 0;
	int next_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.requested_hz <= '0;
			send_gap <= 0;
		end else if (req.valid && req.ready) begin
			expected_plans.push_back(compute_plan(req.requested_hz));
			next_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
			if (next_gap == 0 && !sender_paused && pending_rates.size() != 0) begin
				req.requested_hz <= pending_rates.pop_front();
			end else begin
				req.valid <= 1'b0;
				send_gap <= (next_gap > 0) ? next_gap - 1 : 0;
			end
		end else if (!req.valid && !sender_paused) begin
			if (send_gap > 0)
				send_gap <= send_gap - 1;
			else if (pending_rates.size() != 0) begin
				req.valid <= 1'b1;
				req.requested_hz <= pending_rates.pop_front();
			end
		end
	end

	// Monitor and sink: random stalls, plus one long hold-off on request.
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			cycles <= cycles + 1;
			if (plan.valid && plan.ready) begin
				plan_t got, want;
				got = {plan.plan_ok, plan.echo_requested_hz, plan.actual_rate_hz,
					plan.prescaler_value, plan.reload_value, plan.deviation_ppm};
				plans_seen <= plans_seen + 1;
				if (got.plan_ok)
					ok_plans <= ok_plans + 1;
				if (expected_plans.size() == 0) begin
					$display("%0t: unexpected plan item %h", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_plans.pop_front();
					if (got !== want) begin
						$display("%0t: plan mismatch expected %h actual %h", $time, want, got);
						errors <= errors + 1;
					end
				end
			end
			if (hold_plan > 0) begin
				hold_plan <= hold_plan - 1;
				plan.ready <= 1'b0;
			end else if (plan.valid && plan.ready || !plan.ready && recv_gap == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					plan.ready <= 1'b1;
					recv_gap <= 0;
				end else begin
					recv_gap <= $urandom_range(0, 18);
					plan.ready <= 1'b0;
				end
			end else if (!plan.ready) begin
				recv_gap <= recv_gap - 1;
				if (recv_gap == 1)
					plan.ready <= 1'b1;
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic run_random(int count);
		for (int i = 0; i < count; i++)
			pending_rates.push_back(random_rate());
	endtask

	initial begin
		timer_clock = trpc_pkg::TIMER_CLOCK_RESET;
		max_rate = trpc_pkg::MAX_RATE_RESET;
		max_reload = trpc_pkg::MAX_RELOAD_RESET;
		max_factor = trpc_pkg::MAX_PRESCALE_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rates[k])
			pending_rates.push_back(directed_rates[k]);
		wait_drained();

		// Wide clock and rate range with a reload limit of zero.
		write_reg(trpc_pkg::REG_TIMER_CLOCK_HZ, 32'hFFFF_FFFF);
		write_reg(trpc_pkg::REG_MAX_RATE_HZ, 32'hFFFF_FFFF);
		write_reg(trpc_pkg::REG_MAX_RELOAD, 32'd0);
		write_reg(trpc_pkg::REG_MAX_PRESCALE_FACTOR, 32'h1FFFF);
		pending_rates.push_back(32'hFFFF_FFFF);
		pending_rates.push_back(32'h8000_0000);
		pending_rates.push_back(32'd1);
		pending_rates.push_back(32'h5555_5555);
		run_random(200);
		// Long hold-off on the plan side while requests keep coming.
		hold_plan = 600;
		wait_drained();

		// Tiny registers: zero factor limit rejects everything, then limit one.
		write_reg(trpc_pkg::REG_TIMER_CLOCK_HZ, 32'd1);
		write_reg(trpc_pkg::REG_MAX_RATE_HZ, 32'd3);
		write_reg(trpc_pkg::REG_MAX_RELOAD, 32'd1);
		write_reg(trpc_pkg::REG_MAX_PRESCALE_FACTOR, 32'd0);
		run_random(40);
		wait_drained();
		write_reg(trpc_pkg::REG_MAX_PRESCALE_FACTOR, 32'd1);
		run_random(60);
		wait_drained();

		// Several random settings; the sender pauses mid-batch until every
		// accepted item has come out, then the registers change.
		for (int s = 0; s < 6; s++) begin
			sender_paused = 1'b1;
			wait_results();
			write_reg(trpc_pkg::REG_TIMER_CLOCK_HZ, $urandom_range(0, 1) ? $urandom() :
				$urandom_range(1, 100000000));
			write_reg(trpc_pkg::REG_MAX_RATE_HZ, $urandom_range(0, 1) ? $urandom() :
				$urandom_range(1, 2000000));
			write_reg(trpc_pkg::REG_MAX_RELOAD, $urandom_range(0, 65535));
			write_reg(trpc_pkg::REG_MAX_PRESCALE_FACTOR, $urandom_range(0, 131071));
			sender_paused = 1'b0;
			run_random(115);
		end
		wait_drained();

		$display("Checked %0d plan items, %0d of them usable plans, over 10 register settings.",
			plans_seen, ok_plans);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
